[rtl/pse_pkg.sv]
// ---------------------------------------------------------------------------
// Postfix stack evaluator package
// Shared types and constants: stack sizing, character codes, payload structs.
// ---------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_POW   = 8'h5E;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam logic signed [7:0] EMPTY_VALUE = -8'sd1;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } in_t;

    typedef struct packed {
        logic signed [7:0] value;
        logic              overflow;
        logic              math_error;
    } out_t;

endpackage

`default_nettype wire

[rtl/postfix_stack_evaluator_core.sv]
// ---------------------------------------------------------------------------
// Postfix stack evaluator core
// Microcoded sequencer over an 8-bit operand stack with iterative divide/power.
// ---------------------------------------------------------------------------
// Per transaction: a digit is latched, decoded and pushed; an operator pops two operands;
// / runs 8 divide steps (none on a zero divisor), ^ one step per bit (none for a negative
// exponent). A transaction marked last adds a pop and an emit, waiting while the result
// register is occupied. One transaction in flight; the program counter sets the pace.
// Reset clears program counter, stack count, sticky flags and output valid; the
// stack memory is not cleared.
`default_nettype none

module postfix_stack_evaluator_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire pse_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output pse_pkg::out_t      m_data
);

    typedef enum logic [3:0] {
        OP_NOP, OP_LATCH, OP_POP_RD, OP_LOAD_B, OP_LOAD_A, OP_ALU,
        OP_DIV_INIT, OP_DIV_STEP, OP_DIV_FIX, OP_POW_INIT, OP_POW_STEP,
        OP_PUSH, OP_EMIT
    } uop_t;

    typedef enum logic [3:0] {
        C_ALWAYS, C_IN_ACCEPT, C_NOT_OPER, C_IS_DIV, C_IS_POW, C_B_ZERO,
        C_DIV_DONE, C_B_NEG, C_POW_DONE, C_NOT_LAST, C_OUT_FREE
    } cond_t;

    typedef logic [3:0] upc_t;

    // next = cond ? target : (stay ? upc : upc + 1)
    typedef struct packed {
        uop_t  op;
        cond_t cond;
        upc_t  target;
        logic  stay;
    } ctrl_t;

    localparam upc_t S_FETCH    = 4'd0;
    localparam upc_t S_DECODE   = 4'd1;
    localparam upc_t S_POP_B    = 4'd2;
    localparam upc_t S_LOAD_B   = 4'd3;
    localparam upc_t S_POP_A    = 4'd4;
    localparam upc_t S_LOAD_A   = 4'd5;
    localparam upc_t S_TEST_POW = 4'd6;
    localparam upc_t S_ALU      = 4'd7;
    localparam upc_t S_DIV_INIT = 4'd8;
    localparam upc_t S_DIV_STEP = 4'd9;
    localparam upc_t S_DIV_FIX  = 4'd10;
    localparam upc_t S_POW_INIT = 4'd11;
    localparam upc_t S_POW_STEP = 4'd12;
    localparam upc_t S_PUSH     = 4'd13;
    localparam upc_t S_POP_OUT  = 4'd14;
    localparam upc_t S_EMIT     = 4'd15;

    function automatic ctrl_t rom_word(input upc_t addr);
        ctrl_t w;
        case (addr)
            S_FETCH:    w = '{OP_LATCH,    C_IN_ACCEPT, S_DECODE,   1'b1};
            S_DECODE:   w = '{OP_NOP,      C_NOT_OPER,  S_PUSH,     1'b0};
            S_POP_B:    w = '{OP_POP_RD,   C_ALWAYS,    S_LOAD_B,   1'b0};
            S_LOAD_B:   w = '{OP_LOAD_B,   C_ALWAYS,    S_POP_A,    1'b0};
            S_POP_A:    w = '{OP_POP_RD,   C_ALWAYS,    S_LOAD_A,   1'b0};
            S_LOAD_A:   w = '{OP_LOAD_A,   C_IS_DIV,    S_DIV_INIT, 1'b0};
            S_TEST_POW: w = '{OP_NOP,      C_IS_POW,    S_POW_INIT, 1'b0};
            S_ALU:      w = '{OP_ALU,      C_ALWAYS,    S_PUSH,     1'b0};
            S_DIV_INIT: w = '{OP_DIV_INIT, C_B_ZERO,    S_PUSH,     1'b0};
            S_DIV_STEP: w = '{OP_DIV_STEP, C_DIV_DONE,  S_DIV_FIX,  1'b1};
            S_DIV_FIX:  w = '{OP_DIV_FIX,  C_ALWAYS,    S_PUSH,     1'b0};
            S_POW_INIT: w = '{OP_POW_INIT, C_B_NEG,     S_PUSH,     1'b0};
            S_POW_STEP: w = '{OP_POW_STEP, C_POW_DONE,  S_PUSH,     1'b1};
            S_PUSH:     w = '{OP_PUSH,     C_NOT_LAST,  S_FETCH,    1'b0};
            S_POP_OUT:  w = '{OP_POP_RD,   C_ALWAYS,    S_EMIT,     1'b0};
            S_EMIT:     w = '{OP_EMIT,     C_OUT_FREE,  S_FETCH,    1'b1};
            default:    w = '{OP_NOP,      C_ALWAYS,    S_FETCH,    1'b0};
        endcase
        return w;
    endfunction

    // sequencer and datapath registers
    upc_t                          upc_reg, upc_next;
    logic [7:0]                    sym_reg, sym_next;
    logic                          last_reg, last_next;
    logic signed [7:0]             a_reg, a_next, b_reg, b_next;
    logic [7:0]                    r_reg, r_next;
    logic                          pop_ok_reg, pop_ok_next;
    logic [pse_pkg::CNT_W-1:0]     count_reg, count_next;
    logic                          ovf_reg, ovf_next, err_reg, err_next;
    logic [7:0]                    dvd_reg, dvd_next, dsr_reg, dsr_next;
    logic [7:0]                    rem_reg, rem_next;
    logic [2:0]                    cnt_reg, cnt_next;
    logic                          neg_reg, neg_next;
    logic [7:0]                    acc_reg, acc_next, sq_reg, sq_next;
    logic [6:0]                    e_reg, e_next;
    logic                          m_valid_reg, m_valid_next;
    pse_pkg::out_t                 m_data_reg, m_data_next;

    // stack memory
    logic [7:0]                    stack_mem [pse_pkg::STACK_DEPTH];
    logic [7:0]                    q_reg;
    logic                          mem_we, mem_re;
    logic [pse_pkg::PTR_W-1:0]     mem_waddr, mem_raddr;

    ctrl_t                         ctrl;
    logic                          cond_hit, in_accept, out_free, is_oper, stack_full;
    logic signed [7:0]             popped;
    logic [8:0]                    trial;
    logic [15:0]                   mul_ab, mul_acc, mul_sq;
    logic [pse_pkg::CNT_W-1:0]     count_dec;

    assign ctrl       = rom_word(upc_reg);
    assign s_ready    = (upc_reg == S_FETCH);
    assign in_accept  = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign is_oper    = sym_reg inside {pse_pkg::CH_PLUS, pse_pkg::CH_MINUS, pse_pkg::CH_MUL,
                                        pse_pkg::CH_DIV, pse_pkg::CH_POW};
    assign stack_full = (count_reg == pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH));
    assign popped     = pop_ok_reg ? $signed(q_reg) : pse_pkg::EMPTY_VALUE;
    assign count_dec  = count_reg - pse_pkg::CNT_W'(1);
    assign trial      = {rem_reg, dvd_reg[7]};
    assign mul_ab     = 16'(a_reg[7:0]) * 16'(b_reg[7:0]);
    assign mul_acc    = 16'(acc_reg) * 16'(sq_reg);
    assign mul_sq     = 16'(sq_reg) * 16'(sq_reg);

    assign mem_waddr  = count_reg[pse_pkg::PTR_W-1:0];
    assign mem_raddr  = count_dec[pse_pkg::PTR_W-1:0];

    always_comb begin
        case (ctrl.cond)
            C_ALWAYS:    cond_hit = 1'b1;
            C_IN_ACCEPT: cond_hit = in_accept;
            C_NOT_OPER:  cond_hit = !is_oper;
            C_IS_DIV:    cond_hit = (sym_reg == pse_pkg::CH_DIV);
            C_IS_POW:    cond_hit = (sym_reg == pse_pkg::CH_POW);
            C_B_ZERO:    cond_hit = (b_reg == 8'sd0);
            C_DIV_DONE:  cond_hit = (cnt_reg == 3'd0);
            C_B_NEG:     cond_hit = b_reg[7];
            C_POW_DONE:  cond_hit = (e_reg[6:1] == 6'd0);
            C_NOT_LAST:  cond_hit = !last_reg;
            C_OUT_FREE:  cond_hit = out_free;
            default:     cond_hit = 1'b1;
        endcase
    end

    always_comb begin
        if (cond_hit) begin
            upc_next = ctrl.target;
        end else if (ctrl.stay) begin
            upc_next = upc_reg;
        end else begin
            upc_next = upc_reg + upc_t'(1);
        end
    end

    always_comb begin
        sym_next     = sym_reg;
        last_next    = last_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        r_next       = r_reg;
        pop_ok_next  = pop_ok_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        err_next     = err_reg;
        dvd_next     = dvd_reg;
        dsr_next     = dsr_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        neg_next     = neg_reg;
        acc_next     = acc_reg;
        sq_next      = sq_reg;
        e_next       = e_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        mem_we       = 1'b0;
        mem_re       = 1'b0;

        case (ctrl.op)
            OP_LATCH: begin
                if (in_accept) begin
                    sym_next  = s_data.symbol;
                    last_next = s_data.last;
                    r_next    = s_data.symbol - pse_pkg::CH_ZERO;
                end
            end
            OP_POP_RD: begin
                mem_re      = 1'b1;
                pop_ok_next = (count_reg != '0);
                if (count_reg != '0) begin
                    count_next = count_dec;
                end
            end
            OP_LOAD_B: b_next = popped;
            OP_LOAD_A: a_next = popped;
            OP_ALU: begin
                case (sym_reg)
                    pse_pkg::CH_PLUS:  r_next = a_reg + b_reg;
                    pse_pkg::CH_MINUS: r_next = a_reg - b_reg;
                    default:           r_next = mul_ab[7:0];
                endcase
            end
            OP_DIV_INIT: begin
                dvd_next = a_reg[7] ? -a_reg : a_reg;
                dsr_next = b_reg[7] ? -b_reg : b_reg;
                rem_next = '0;
                cnt_next = 3'd7;
                neg_next = a_reg[7] ^ b_reg[7];
                if (b_reg == 8'sd0) begin
                    err_next = 1'b1;
                    r_next   = '0;
                end
            end
            OP_DIV_STEP: begin
                // restoring division, one quotient bit per step
                if (trial >= {1'b0, dsr_reg}) begin
                    rem_next = 8'(trial - {1'b0, dsr_reg});
                    dvd_next = {dvd_reg[6:0], 1'b1};
                end else begin
                    rem_next = trial[7:0];
                    dvd_next = {dvd_reg[6:0], 1'b0};
                end
                cnt_next = cnt_reg - 3'd1;
            end
            OP_DIV_FIX: r_next = neg_reg ? -dvd_reg : dvd_reg;
            OP_POW_INIT: begin
                if (b_reg[7]) begin
                    // negative exponent: only bases 1 and -1 survive
                    if (a_reg == 8'sd1) begin
                        r_next = 8'd1;
                    end else if (a_reg == -8'sd1) begin
                        r_next = b_reg[0] ? 8'hFF : 8'd1;
                    end else begin
                        r_next = '0;
                    end
                    if (a_reg == 8'sd0) begin
                        err_next = 1'b1;
                    end
                end else begin
                    acc_next = 8'd1;
                    sq_next  = a_reg;
                    e_next   = b_reg[6:0];
                end
            end
            OP_POW_STEP: begin
                acc_next = e_reg[0] ? mul_acc[7:0] : acc_reg;
                r_next   = acc_next;
                sq_next  = mul_sq[7:0];
                e_next   = {1'b0, e_reg[6:1]};
            end
            OP_PUSH: begin
                if (stack_full) begin
                    ovf_next = 1'b1;
                end else begin
                    mem_we     = 1'b1;
                    count_next = count_reg + pse_pkg::CNT_W'(1);
                end
            end
            OP_EMIT: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.value      = popped;
                    m_data_next.overflow   = ovf_reg;
                    m_data_next.math_error = err_reg;
                    count_next             = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg     <= S_FETCH;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            upc_reg     <= upc_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
        sym_reg    <= sym_next;
        last_reg   <= last_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        r_reg      <= r_next;
        pop_ok_reg <= pop_ok_next;
        dvd_reg    <= dvd_next;
        dsr_reg    <= dsr_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        neg_reg    <= neg_next;
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        e_reg      <= e_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[mem_waddr] <= r_reg;
        end
        if (mem_re) begin
            q_reg <= stack_mem[mem_raddr];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

[rtl/pse_checker.sv]
// ---------------------------------------------------------------------------
// Postfix stack evaluator port checker
// Port-level properties of the core, bound to the core module.
// ---------------------------------------------------------------------------
`default_nettype none

module pse_checker (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_valid,
    input wire logic          s_ready,
    input wire pse_pkg::in_t  s_data,
    input wire logic          m_valid,
    input wire logic          m_ready,
    input wire pse_pkg::out_t m_data
);

    logic [1:0] pending_reg;
    logic       ovf_seen_reg;
    logic       err_seen_reg;
    logic       s_fire, m_fire, end_fire;

    assign s_fire   = s_valid && s_ready;
    assign m_fire   = m_valid && m_ready;
    assign end_fire = s_fire && s_data.last;

    // expressions ended but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg  <= '0;
            ovf_seen_reg <= 1'b0;
            err_seen_reg <= 1'b0;
        end else begin
            pending_reg <= pending_reg + 2'(end_fire) - 2'(m_fire);
            if (m_fire && m_data.overflow) begin
                ovf_seen_reg <= 1'b1;
            end
            if (m_fire && m_data.math_error) begin
                err_seen_reg <= 1'b1;
            end
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (pending_reg != 2'd0))
        else $error("result without an ended expression");

    a_ovf_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && ovf_seen_reg) |-> m_data.overflow)
        else $error("overflow flag cleared");

    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && err_seen_reg) |-> m_data.math_error)
        else $error("math error flag cleared");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("input taken while a transaction is in progress");

endmodule

bind postfix_stack_evaluator_core pse_checker u_pse_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
